FILE: design/tctt_pkg.sv
package tctt_pkg;

	localparam int STORED_ENTRIES = 101;
	localparam int IDX_W          = 7;
	localparam int RES_W          = 15;
	localparam int CODE_W         = 16;
	localparam int MV_W           = 14;
	localparam int PULLUP_W       = 16;
	localparam int SUPPLY_W       = 14;
	localparam int TEMP_W         = 14;
	localparam int STATUS_W       = 2;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;
	localparam int MUL_W          = 16;
	localparam int PROD_W         = 32;
	localparam int DIV_W          = 25;
	localparam int FRAC_W         = 7;

	localparam logic [MUL_W-1:0]  MV_SCALE      = 16'd15259;
	localparam logic [DIV_W-1:0]  MV_DIVISOR    = 25'd100000;
	localparam logic [6:0]        CENTI         = 7'd100;
	localparam logic [15:0]       PULLUP_RESET  = 16'd4700;
	localparam logic [13:0]       SUPPLY_RESET  = 14'd5000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PULLUP = 2'd0,
		REG_SUPPLY = 2'd1
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_IN_TABLE    = 2'd0,
		STAT_OVER_SUPPLY = 2'd1,
		STAT_BELOW_TABLE = 2'd2,
		STAT_ABOVE_TABLE = 2'd3
	} status_t;

	typedef struct packed {
		logic             start;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	// thermistor resistance in ohms, one entry per degree from 0 C
	localparam logic [RES_W-1:0] RES_TABLE [STORED_ENTRIES] = '{
		15'd27280, 15'd26140, 15'd25050, 15'd24010, 15'd23020,
		15'd22070, 15'd21170, 15'd20310, 15'd19490, 15'd18710,
		15'd17960, 15'd17250, 15'd16570, 15'd15910, 15'd15290,
		15'd14700, 15'd14130, 15'd13590, 15'd13070, 15'd12570,
		15'd12090, 15'd11640, 15'd11200, 15'd10780, 15'd10380,
		15'd10000, 15'd9633,  15'd9282,  15'd8945,  15'd8622,
		15'd8312,  15'd8015,  15'd7730,  15'd7456,  15'd7194,
		15'd6942,  15'd6700,  15'd6468,  15'd6245,  15'd6031,
		15'd5826,  15'd5628,  15'd5438,  15'd5255,  15'd5080,
		15'd4911,  15'd4749,  15'd4592,  15'd4442,  15'd4297,
		15'd4158,  15'd4024,  15'd3895,  15'd3771,  15'd3651,
		15'd3536,  15'd3425,  15'd3318,  15'd3215,  15'd3115,
		15'd3019,  15'd2927,  15'd2837,  15'd2751,  15'd2668,
		15'd2588,  15'd2511,  15'd2436,  15'd2364,  15'd2295,
		15'd2227,  15'd2163,  15'd2100,  15'd2039,  15'd1981,
		15'd1924,  15'd1869,  15'd1817,  15'd1765,  15'd1716,
		15'd1668,  15'd1622,  15'd1577,  15'd1534,  15'd1492,
		15'd1451,  15'd1412,  15'd1374,  15'd1337,  15'd1302,
		15'd1267,  15'd1234,  15'd1201,  15'd1170,  15'd1139,
		15'd1110,  15'd1081,  15'd1053,  15'd1027,  15'd1001,
		15'd975
	};

endpackage

FILE: design/tctt_cfg_if.sv
interface tctt_cfg_if
	import tctt_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/tctt_code_if.sv
interface tctt_code_if
	import tctt_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [7:0] code_high_byte;
	logic [7:0] code_low_byte;

	modport source (output valid, output code_high_byte, output code_low_byte, input ready);
	modport sink (input valid, input code_high_byte, input code_low_byte, output ready);
endinterface

FILE: design/tctt_temp_if.sv
interface tctt_temp_if
	import tctt_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [TEMP_W-1:0]   temperature_centi_c;
	logic [STATUS_W-1:0] range_status;

	modport source (output valid, output temperature_centi_c, output range_status, input ready);
	modport sink (input valid, input temperature_centi_c, input range_status, output ready);
endinterface

FILE: design/thermistor_code_to_temperature_core.sv
// channel  dir  fields                                   word accepted when
// cfg      in   index[1:0], data[15:0]                   cfg.valid & cfg.ready
// code     in   code_high_byte[7:0], code_low_byte[7:0]  code.valid & code.ready
// temp     out  temperature_centi_c[13:0], range_status  temp.valid & temp.ready
//
// One word in flight; a word makes up to eleven uses of the radix-4 multiplier
// (seven in the table search) and uses the 1-bit divider (14 steps for
// millivolts, 7 for the fraction). arst_n clears control and loads register
// defaults. cfg is always ready; a finished word waits in the output register
// and a full one stalls the core.
module thermistor_code_to_temperature_core
	import tctt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 101
)(
	input  logic clk,
	input  logic arst_n,
	tctt_cfg_if.sink    cfg,
	tctt_code_if.sink   code,
	tctt_temp_if.source temp
);

	localparam int LIMIT_I = (TABLE_ENTRIES < STORED_ENTRIES) ? TABLE_ENTRIES : STORED_ENTRIES;
	localparam logic [IDX_W-1:0]  LIMIT     = IDX_W'(LIMIT_I);
	localparam logic [TEMP_W-1:0] OVER_TEMP = TEMP_W'((TABLE_ENTRIES * 100) % 16384);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_MV_MUL   = 9'b000000010,
		S_MV_DIV   = 9'b000000100,
		S_NUM_MUL  = 9'b000001000,
		S_PROBE    = 9'b000010000,
		S_HI_MUL   = 9'b000100000,
		S_SPAN_MUL = 9'b001000000,
		S_FRAC_DIV = 9'b010000000,
		S_OUT      = 9'b100000000
	} state_t;

	state_t               state_q;
	logic [PULLUP_W-1:0]  pullup_q;
	logic [SUPPLY_W-1:0]  supply_q;
	logic                 mul_start_q;
	logic                 mul_start_nx;
	logic [MUL_W-1:0]     mul_a_q;
	logic [MUL_W-1:0]     mul_b_q;
	mul_req_t             mul_req;
	logic                 mul_done;
	logic [PROD_W-1:0]    prod;

	logic [MV_W-1:0]      den_q;
	logic [29:0]          num_q;
	logic [IDX_W-1:0]     lo_q;
	logic [IDX_W-1:0]     hi_q;
	logic [IDX_W-1:0]     idx_q;
	logic [DIV_W-1:0]     x_q;

	logic [DIV_W-1:0]     rem_q;
	logic [PROD_W-1:0]    dvd_q;
	logic [MV_W-1:0]      quo_q;
	logic [DIV_W-1:0]     dsor_q;
	logic [3:0]           cnt_q;

	logic [TEMP_W-1:0]    res_temp_q;
	status_t              res_status_q;
	logic                 out_valid_q;
	logic [TEMP_W-1:0]    out_temp_q;
	logic [STATUS_W-1:0]  out_status_q;

	logic [DIV_W:0]       shifted;
	logic                 ge;
	logic [DIV_W-1:0]     rem_nx;
	logic [MV_W-1:0]      quo_nx;
	logic [IDX_W:0]       mid_sum;
	logic [IDX_W-1:0]     mid;
	logic                 less;
	logic [IDX_W-1:0]     lo_nx;
	logic [IDX_W-1:0]     hi_nx;
	logic [IDX_W:0]       nmid_sum;
	logic [PROD_W-1:0]    scaled;
	logic [RES_W-1:0]     span_res;
	logic                 code_take;

	assign mul_req = {mul_start_q, mul_a_q, mul_b_q};

	tctt_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.done    (mul_done),
		.product (prod)
	);

	assign cfg.ready  = 1'b1;
	assign code.ready = (state_q == S_IDLE);
	assign code_take  = code.valid && (state_q == S_IDLE);

	assign temp.valid               = out_valid_q;
	assign temp.temperature_centi_c = out_temp_q;
	assign temp.range_status        = out_status_q;

	// restoring divider step
	assign shifted = {rem_q, dvd_q[PROD_W-1]};
	assign ge      = shifted >= {1'b0, dsor_q};
	assign rem_nx  = ge ? DIV_W'(shifted - {1'b0, dsor_q}) : shifted[DIV_W-1:0];
	assign quo_nx  = {quo_q[MV_W-2:0], ge};

	// binary search for first entry with T*den < num
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[IDX_W:1];
	assign less     = prod[29:0] < num_q;
	assign lo_nx    = less ? lo_q : IDX_W'(mid + 1'b1);
	assign hi_nx    = less ? mid : hi_q;
	assign nmid_sum = {1'b0, lo_nx} + {1'b0, hi_nx};

	assign scaled   = PROD_W'(x_q) * PROD_W'(CENTI);
	assign span_res = RES_TABLE[idx_q] - RES_TABLE[IDX_W'(idx_q + 1'b1)];

	always_comb begin
		unique case (state_q)
			S_IDLE:    mul_start_nx = code_take;
			S_MV_DIV:  mul_start_nx = (cnt_q == 4'd1) && (quo_nx < supply_q);
			S_NUM_MUL: mul_start_nx = mul_done;
			S_PROBE:   mul_start_nx = mul_done
			                          && !((lo_nx == hi_nx) && (lo_nx == '0 || lo_nx == LIMIT));
			S_HI_MUL:  mul_start_nx = mul_done;
			default:   mul_start_nx = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pullup_q <= PULLUP_RESET;
			supply_q <= SUPPLY_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PULLUP: pullup_q <= cfg.data;
				REG_SUPPLY: supply_q <= cfg.data[SUPPLY_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mul_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mul_start_q <= mul_start_nx;
			if (state_q == S_OUT && (!out_valid_q || temp.ready))
				out_valid_q <= 1'b1;
			else if (temp.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (code_take)
						state_q <= S_MV_MUL;
				end
				S_MV_MUL: begin
					if (mul_done)
						state_q <= S_MV_DIV;
				end
				S_MV_DIV: begin
					if (cnt_q == 4'd1) begin
						if (quo_nx >= supply_q)
							state_q <= S_OUT;
						else
							state_q <= S_NUM_MUL;
					end
				end
				S_NUM_MUL: begin
					if (mul_done)
						state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (mul_done && lo_nx == hi_nx) begin
						if (lo_nx == '0 || lo_nx == LIMIT)
							state_q <= S_OUT;
						else
							state_q <= S_HI_MUL;
					end
				end
				S_HI_MUL: begin
					if (mul_done)
						state_q <= S_SPAN_MUL;
				end
				S_SPAN_MUL: begin
					if (mul_done)
						state_q <= S_FRAC_DIV;
				end
				S_FRAC_DIV: begin
					if (cnt_q == 4'd1)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || temp.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				mul_a_q <= MV_SCALE;
				mul_b_q <= {code.code_high_byte, code.code_low_byte};
			end
			S_MV_MUL: begin
				if (mul_done) begin
					rem_q  <= DIV_W'(prod[29:MV_W]);
					dvd_q  <= {prod[MV_W-1:0], (PROD_W-MV_W)'(0)};
					quo_q  <= '0;
					dsor_q <= MV_DIVISOR;
					cnt_q  <= 4'(MV_W);
				end
			end
			S_MV_DIV, S_FRAC_DIV: begin
				rem_q <= rem_nx;
				dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
				quo_q <= quo_nx;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 4'd1) begin
					if (state_q == S_MV_DIV) begin
						res_temp_q   <= '0;
						res_status_q <= STAT_OVER_SUPPLY;
						den_q        <= supply_q - quo_nx;
						mul_a_q      <= pullup_q;
						mul_b_q      <= MUL_W'(quo_nx);
					end else begin
						res_temp_q   <= TEMP_W'(TEMP_W'(idx_q) * TEMP_W'(CENTI))
						              + TEMP_W'(quo_nx[FRAC_W-1:0]);
						res_status_q <= STAT_IN_TABLE;
					end
				end
			end
			S_NUM_MUL: begin
				if (mul_done) begin
					num_q   <= prod[29:0];
					lo_q    <= '0;
					hi_q    <= LIMIT;
					mul_a_q <= MUL_W'(RES_TABLE[LIMIT >> 1]);
					mul_b_q <= MUL_W'(den_q);
				end
			end
			S_PROBE: begin
				if (mul_done) begin
					lo_q    <= lo_nx;
					hi_q    <= hi_nx;
					idx_q   <= IDX_W'(lo_nx - 1'b1);
					mul_a_q <= lo_nx == hi_nx
					           ? MUL_W'(RES_TABLE[IDX_W'(lo_nx - 1'b1)])
					           : MUL_W'(RES_TABLE[nmid_sum[IDX_W:1]]);
					if (lo_nx == '0) begin
						res_temp_q   <= '0;
						res_status_q <= STAT_BELOW_TABLE;
					end else begin
						res_temp_q   <= OVER_TEMP;
						res_status_q <= STAT_ABOVE_TABLE;
					end
				end
			end
			S_HI_MUL: begin
				if (mul_done) begin
					x_q     <= DIV_W'(prod[29:0] - num_q);
					mul_a_q <= MUL_W'(span_res);
				end
			end
			S_SPAN_MUL: begin
				if (mul_done) begin
					rem_q  <= scaled[PROD_W-1:FRAC_W];
					dvd_q  <= {scaled[FRAC_W-1:0], (PROD_W-FRAC_W)'(0)};
					quo_q  <= '0;
					dsor_q <= prod[DIV_W-1:0];
					cnt_q  <= 4'(FRAC_W);
				end
			end
			S_OUT: begin
				if (!out_valid_q || temp.ready) begin
					out_temp_q   <= res_temp_q;
					out_status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: design/tctt_mul.sv
// radix-4 shift-add multiplier, two multiplier bits per cycle
module tctt_mul
	import tctt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mul_req_t          req,
	output logic              done,
	output logic [PROD_W-1:0] product
);

	localparam int DIGITS = MUL_W / 2;
	localparam int CNT_W  = $clog2(DIGITS);

	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] mcand_q;
	logic [MUL_W-1:0]  mplier_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [PROD_W-1:0] pp;

	always_comb begin
		pp = '0;
		if (mplier_q[0])
			pp = pp + mcand_q;
		if (mplier_q[1])
			pp = pp + {mcand_q[PROD_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(DIGITS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIGITS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			mcand_q  <= PROD_W'(req.a);
			mplier_q <= req.b;
		end else if (busy_q) begin
			acc_q    <= acc_q + pp;
			mcand_q  <= {mcand_q[PROD_W-3:0], 2'b00};
			mplier_q <= {2'b00, mplier_q[MUL_W-1:2]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule
